@@ hdl/gcc_pkg.sv @@
package gcc_pkg;

  // Default store and cell limits
  localparam int MAX_GLYPH_W_DEF = 64;
  localparam int MAX_GLYPH_H_DEF = 64;
  localparam int MAX_CELL_W_DEF  = 64;
  localparam int MAX_CELL_H_DEF  = 64;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORE_ARGB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_ARGB  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_OFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_H     = 3'd6;

  // Register reset values
  localparam logic [31:0] FORE_ARGB_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] BACK_ARGB_RST = 32'h0000_0000;
  localparam logic [6:0]  GLYPH_W_RST   = 7'd0;
  localparam logic [6:0]  GLYPH_H_RST   = 7'd0;
  localparam logic [7:0]  VERT_OFF_RST  = 8'd0;
  localparam logic [6:0]  CELL_W_RST    = 7'd16;
  localparam logic [6:0]  CELL_H_RST    = 7'd16;

  // Operation codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Color constants
  localparam logic [31:0] RB_MASK    = 32'h00FF_00FF;
  localparam logic [31:0] G_MASK     = 32'h0000_FF00;
  localparam logic [31:0] A_OPAQUE   = 32'hFF00_0000;
  localparam logic [7:0]  FULL_COVER = 8'hFF;
  localparam logic [7:0]  NO_COVER   = 8'h00;

  localparam int COV_W = 8;

  typedef struct packed {
    logic       func;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] coverage;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [6:0]  used_width;
  } out_word_t;

  // Lookup result handed from the address stage to the output stage
  typedef struct packed {
    logic       on_glyph;
    logic [6:0] used_width;
  } geom_t;

endpackage

@@ hdl/glyph_cell_compositor_top.sv @@
// Read word: result passes through the store read register, then the output register.
// Load word: written into the glyph store at acceptance, produces no result.
// Throughput: one word per cycle while the output is not stalled; the single glyph store
// port pair sets this rate.
// Reset (rst_n low, synchronous) clears the pipeline valids and restores the configuration
// registers to their defaults; the glyph store is not cleared and must be loaded first.
module glyph_cell_compositor_top #(
  parameter int MAX_GLYPH_W = gcc_pkg::MAX_GLYPH_W_DEF,
  parameter int MAX_GLYPH_H = gcc_pkg::MAX_GLYPH_H_DEF,
  parameter int MAX_CELL_W  = gcc_pkg::MAX_CELL_W_DEF,
  parameter int MAX_CELL_H  = gcc_pkg::MAX_CELL_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gcc_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gcc_pkg::out_word_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int DEPTH  = MAX_GLYPH_W * MAX_GLYPH_H;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [31:0] fore_argb_r, back_argb_r;
  logic [6:0]  glyph_w_r, glyph_h_r, cell_w_r, cell_h_r;
  logic [7:0]  vert_off_r;

  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;

  gcc_pkg::geom_t    geom, s1_geom_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_ok, in_acc, rd_en, wr_en, advance;
  logic [7:0]        cov;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[gcc_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_argb_r <= gcc_pkg::FORE_ARGB_RST;
      back_argb_r <= gcc_pkg::BACK_ARGB_RST;
      glyph_w_r   <= gcc_pkg::GLYPH_W_RST;
      glyph_h_r   <= gcc_pkg::GLYPH_H_RST;
      vert_off_r  <= gcc_pkg::VERT_OFF_RST;
      cell_w_r    <= gcc_pkg::CELL_W_RST;
      cell_h_r    <= gcc_pkg::CELL_H_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gcc_pkg::REG_FORE_ARGB: fore_argb_r <= pwdata;
        gcc_pkg::REG_BACK_ARGB: back_argb_r <= pwdata;
        gcc_pkg::REG_GLYPH_W:   glyph_w_r   <= pwdata[6:0];
        gcc_pkg::REG_GLYPH_H:   glyph_h_r   <= pwdata[6:0];
        gcc_pkg::REG_VERT_OFF:  vert_off_r  <= pwdata[7:0];
        gcc_pkg::REG_CELL_W:    cell_w_r    <= pwdata[6:0];
        gcc_pkg::REG_CELL_H:    cell_h_r    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gcc_pkg::REG_FORE_ARGB: prdata = fore_argb_r;
      gcc_pkg::REG_BACK_ARGB: prdata = back_argb_r;
      gcc_pkg::REG_GLYPH_W:   prdata = {25'd0, glyph_w_r};
      gcc_pkg::REG_GLYPH_H:   prdata = {25'd0, glyph_h_r};
      gcc_pkg::REG_VERT_OFF:  prdata = {24'd0, vert_off_r};
      gcc_pkg::REG_CELL_W:    prdata = {25'd0, cell_w_r};
      gcc_pkg::REG_CELL_H:    prdata = {25'd0, cell_h_r};
      default:                prdata = '0;
    endcase
  end

  gcc_geom #(
    .MAX_GLYPH_W (MAX_GLYPH_W),
    .MAX_GLYPH_H (MAX_GLYPH_H),
    .MAX_CELL_W  (MAX_CELL_W),
    .MAX_CELL_H  (MAX_CELL_H),
    .ADDR_W      (ADDR_W)
  ) u_geom (
    .in_data         (in_data),
    .glyph_width     (glyph_w_r),
    .glyph_height    (glyph_h_r),
    .vertical_offset (vert_off_r),
    .cell_width      (cell_w_r),
    .cell_height     (cell_h_r),
    .geom            (geom),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .wr_ok           (wr_ok)
  );

  // Store read stage holds while the output register is stalled
  assign in_ready = !s1_valid_r || advance;
  assign in_acc   = in_valid && in_ready;
  assign rd_en    = in_acc && (in_data.func == gcc_pkg::FUNC_READ);
  assign wr_en    = in_acc && (in_data.func == gcc_pkg::FUNC_LOAD) && wr_ok;

  gcc_ram #(
    .DATA_W (gcc_pkg::COV_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_data.coverage),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cov)
  );

  assign s1_valid_nxt = in_ready ? rd_en : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (rd_en) begin
      s1_geom_r <= geom;
    end
  end

  gcc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_geom   (s1_geom_r),
    .cov       (cov),
    .fore_argb (fore_argb_r),
    .back_argb (back_argb_r),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/gcc_ram.sv @@
module gcc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/gcc_geom.sv @@
module gcc_geom #(
  parameter int MAX_GLYPH_W = gcc_pkg::MAX_GLYPH_W_DEF,
  parameter int MAX_GLYPH_H = gcc_pkg::MAX_GLYPH_H_DEF,
  parameter int MAX_CELL_W  = gcc_pkg::MAX_CELL_W_DEF,
  parameter int MAX_CELL_H  = gcc_pkg::MAX_CELL_H_DEF,
  parameter int ADDR_W      = $clog2(MAX_GLYPH_W * MAX_GLYPH_H)
) (
  input  gcc_pkg::in_word_t  in_data,
  input  logic [6:0]         glyph_width,
  input  logic [6:0]         glyph_height,
  input  logic [7:0]         vertical_offset,
  input  logic [6:0]         cell_width,
  input  logic [6:0]         cell_height,
  output gcc_pkg::geom_t     geom,
  output logic [ADDR_W-1:0]  rd_addr,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic               wr_ok
);

  function automatic logic [6:0] sat_dim(input logic [6:0] v, input int mx);
    logic [8:0] lim;
    lim = 9'(mx);
    if ({2'b00, v} > lim) begin
      return 7'(mx);
    end
    return v;
  endfunction

  logic [6:0]        gw, gh, cw, ch, w, yoff, half;
  logic              narrow, in_cell, in_glyph;
  logic signed [7:0] diff, x_off;
  logic [7:0]        mag;
  logic signed [8:0] gy, gx;

  always_comb begin
    gw = sat_dim(glyph_width, MAX_GLYPH_W);
    gh = sat_dim(glyph_height, MAX_GLYPH_H);
    cw = sat_dim(cell_width, MAX_CELL_W);
    ch = sat_dim(cell_height, MAX_CELL_H);

    // halve the cell for a narrow glyph
    narrow = ({2'b00, gw} + {1'b0, gw, 1'b0}) < {1'b0, cw, 1'b0};
    w = narrow ? {1'b0, cw[6:1]} : cw;

    // centering offset truncates toward zero
    diff  = $signed({1'b0, w}) - $signed({1'b0, gw});
    mag   = diff[7] ? 8'(-diff) : 8'(diff);
    half  = mag[7:1];
    x_off = diff[7] ? -$signed({1'b0, half}) : $signed({1'b0, half});

    yoff = vertical_offset[7] ? 7'd0 : vertical_offset[6:0];

    gy = $signed({3'b000, in_data.row}) - $signed({2'b00, yoff});
    gx = $signed({3'b000, in_data.col}) - $signed({x_off[7], x_off});

    in_cell  = ({1'b0, in_data.row} < ch) && ({1'b0, in_data.col} < w);
    in_glyph = !gy[8] && (gy[7:0] < {1'b0, gh}) && !gx[8] && (gx[7:0] < {1'b0, gw});

    geom.on_glyph   = in_cell && in_glyph;
    geom.used_width = w;

    rd_addr = ADDR_W'(32'(gy[7:0]) * 32'(MAX_GLYPH_W) + 32'(gx[7:0]));
    wr_addr = ADDR_W'(32'(in_data.row) * 32'(MAX_GLYPH_W) + 32'(in_data.col));
    wr_ok   = (32'(in_data.row) < 32'(MAX_GLYPH_H)) && (32'(in_data.col) < 32'(MAX_GLYPH_W));
  end

endmodule

@@ hdl/gcc_out.sv @@
module gcc_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  gcc_pkg::geom_t     s1_geom,
  input  logic [7:0]         cov,
  input  logic [31:0]        fore_argb,
  input  logic [31:0]        back_argb,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output gcc_pkg::out_word_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  gcc_pkg::out_word_t out_data_r, out_data_nxt;
  logic [31:0]        brb, bgg, frb, fgg, prod_rb, prod_g, rb, g, pix;

  always_comb begin
    brb     = back_argb & gcc_pkg::RB_MASK;
    bgg     = back_argb & gcc_pkg::G_MASK;
    frb     = fore_argb & gcc_pkg::RB_MASK;
    fgg     = fore_argb & gcc_pkg::G_MASK;
    // modular 32-bit products, as packed red/blue and lone green
    prod_rb = 32'((frb - brb) * {24'd0, cov});
    prod_g  = 32'((fgg - bgg) * {24'd0, cov});
    rb      = (prod_rb >> 8) + brb;
    g       = (prod_g >> 8) + bgg;

    if (!s1_geom.on_glyph || cov == gcc_pkg::NO_COVER) begin
      pix = back_argb;
    end else if (cov == gcc_pkg::FULL_COVER) begin
      pix = fore_argb;
    end else begin
      pix = (rb & gcc_pkg::RB_MASK) | (g & gcc_pkg::G_MASK) | gcc_pkg::A_OPAQUE;
    end
  end

  assign advance = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = s1_valid;
      if (s1_valid) begin
        out_data_nxt.pixel_color = pix;
        out_data_nxt.used_width  = s1_geom.used_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/gcc_checker.sv @@
module gcc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input gcc_pkg::out_word_t             out_data,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [gcc_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [gcc_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [gcc_pkg::CFG_DATA_W-1:0] prdata,
  input logic                           pready
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Input side stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // No result word right out of reset
  a_rst_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Foreground color write reads back
  a_fg_rdback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     paddr[gcc_pkg::CFG_ADDR_W-1:2] == gcc_pkg::REG_FORE_ARGB)
    ##1 (psel && !pwrite && paddr[gcc_pkg::CFG_ADDR_W-1:2] == gcc_pkg::REG_FORE_ARGB)
    |-> prdata == $past(pwdata))
    else $error("foreground color readback mismatch");

endmodule

bind glyph_cell_compositor_top gcc_checker u_gcc_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import gcc_pkg::*;

  localparam int GLYPH_COLS   = MAX_GLYPH_W_DEF;
  localparam int GLYPH_ROWS   = MAX_GLYPH_H_DEF;
  localparam int CELL_COLS    = MAX_CELL_W_DEF;
  localparam int CELL_ROWS    = MAX_CELL_H_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register shadow used for prediction
  logic [31:0] cfg_fg = FORE_ARGB_RST;
  logic [31:0] cfg_bg = BACK_ARGB_RST;
  logic [6:0]  cfg_gw = GLYPH_W_RST;
  logic [6:0]  cfg_gh = GLYPH_H_RST;
  logic [7:0]  cfg_voff = VERT_OFF_RST;
  logic [6:0]  cfg_cw = CELL_W_RST;
  logic [6:0]  cfg_ch = CELL_H_RST;

  logic [7:0] cov_store [GLYPH_COLS*GLYPH_ROWS];
  bit         loaded [GLYPH_COLS*GLYPH_ROWS];

  in_word_t  pending_words [$];
  out_word_t pixel_expect [$];

  int  words_queued = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_gaps_on = 1'b0;
  bit  pressure_go = 1'b0;
  bit  rx_hold = 1'b0;

  glyph_cell_compositor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  function automatic int glyph_cols();
    return (cfg_gw > GLYPH_COLS) ? GLYPH_COLS : int'(cfg_gw);
  endfunction

  function automatic int glyph_rows();
    return (cfg_gh > GLYPH_ROWS) ? GLYPH_ROWS : int'(cfg_gh);
  endfunction

  function automatic int cell_rows();
    return (cfg_ch > CELL_ROWS) ? CELL_ROWS : int'(cfg_ch);
  endfunction

  // Narrow glyphs get a half-width cell
  function automatic int cell_cols();
    int w;
    w = (cfg_cw > CELL_COLS) ? CELL_COLS : int'(cfg_cw);
    if (3 * glyph_cols() < 2 * w) w = w / 2;
    return w;
  endfunction

  // Store index shown at a cell pixel, -1 for background
  function automatic int store_slot(input logic [5:0] row, input logic [5:0] col);
    int w, x_off, y_off, gx, gy;
    w = cell_cols();
    x_off = (w - glyph_cols()) / 2;
    y_off = int'($signed(cfg_voff));
    if (y_off < 0) y_off = 0;
    if (int'(row) >= cell_rows() || int'(col) >= w) return -1;
    gy = int'(row) - y_off;
    gx = int'(col) - x_off;
    if (gy < 0 || gy >= glyph_rows() || gx < 0 || gx >= glyph_cols()) return -1;
    return gy * GLYPH_COLS + gx;
  endfunction

  function automatic logic [31:0] blend_cov(input logic [7:0] a);
    logic [31:0] a32, b_rb, b_g, f_rb, f_g, rb, g;
    if (a == NO_COVER) return cfg_bg;
    if (a == FULL_COVER) return cfg_fg;
    a32 = {24'd0, a};
    b_rb = cfg_bg & RB_MASK;
    b_g = cfg_bg & G_MASK;
    f_rb = cfg_fg & RB_MASK;
    f_g = cfg_fg & G_MASK;
    rb = f_rb - b_rb;
    rb = rb * a32;
    rb = (rb >> 8) + b_rb;
    g = f_g - b_g;
    g = g * a32;
    g = (g >> 8) + b_g;
    return (rb & RB_MASK) | (g & G_MASK) | A_OPAQUE;
  endfunction

  function automatic out_word_t cell_pixel(input logic [5:0] row, input logic [5:0] col);
    out_word_t o;
    int idx;
    idx = store_slot(row, col);
    o.pixel_color = (idx < 0) ? cfg_bg : blend_cov(cov_store[idx]);
    o.used_width = 7'(cell_cols());
    return o;
  endfunction

  function automatic logic [7:0] rand_cov();
    case ($urandom_range(0, 5))
      0: return NO_COVER;
      1: return FULL_COVER;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] rand_glyph_dim();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [6:0] rand_cell_dim();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'd1;
      default: return 7'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [7:0] rand_offset();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'($urandom_range(0, 255));
      3: return 8'd0 - 8'($urandom_range(1, 10));
      default: return 8'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FORE_ARGB: cfg_fg = value;
      REG_BACK_ARGB: cfg_bg = value;
      REG_GLYPH_W:   cfg_gw = value[6:0];
      REG_GLYPH_H:   cfg_gh = value[6:0];
      REG_VERT_OFF:  cfg_voff = value[7:0];
      REG_CELL_W:    cfg_cw = value[6:0];
      REG_CELL_H:    cfg_ch = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_cell(input logic [31:0] fg, input logic [31:0] bg,
                          input logic [6:0] gw, input logic [6:0] gh,
                          input logic [7:0] voff, input logic [6:0] cw,
                          input logic [6:0] ch);
    cfg_write(REG_FORE_ARGB, fg);
    cfg_write(REG_BACK_ARGB, bg);
    cfg_write(REG_GLYPH_W, {25'd0, gw});
    cfg_write(REG_GLYPH_H, {25'd0, gh});
    cfg_write(REG_VERT_OFF, {24'd0, voff});
    cfg_write(REG_CELL_W, {25'd0, cw});
    cfg_write(REG_CELL_H, {25'd0, ch});
  endtask

  task automatic push_load(input logic [5:0] row, input logic [5:0] col,
                           input logic [7:0] cov);
    in_word_t w;
    w.func = FUNC_LOAD;
    w.row = row;
    w.col = col;
    w.coverage = cov;
    pending_words.push_back(w);
    loaded[int'(row) * GLYPH_COLS + int'(col)] = 1'b1;
    words_queued++;
  endtask

  // Load the glyph sample first if the pixel lands on one never written
  task automatic push_read(input logic [5:0] row, input logic [5:0] col);
    in_word_t w;
    int idx;
    idx = store_slot(row, col);
    if (idx >= 0 && !loaded[idx])
      push_load(6'(idx / GLYPH_COLS), 6'(idx % GLYPH_COLS), rand_cov());
    w.func = FUNC_READ;
    w.row = row;
    w.col = col;
    w.coverage = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || pixel_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin : word_driver
    if (rst_n && !(in_valid && !in_took)) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait = tx_wait - 1;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
        tx_wait = tx_gaps_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_took) begin
      rx_wait = rx_gaps_on ? $urandom_range(0, 10) : 0;
      if (rx_wait == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_wait = rx_wait - 1;
      end
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold so the pipeline backs up into the input
  initial begin
    wait (pressure_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : pixel_monitor
    out_word_t want;
    in_took <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      if (in_data.func == FUNC_LOAD)
        cov_store[int'(in_data.row) * GLYPH_COLS + int'(in_data.col)] = in_data.coverage;
      else
        pixel_expect.push_back(cell_pixel(in_data.row, in_data.col));
    end
    if (rst_n && out_valid && out_ready) begin
      if (pixel_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: color %h width %0d",
                   out_data.pixel_color, out_data.used_width);
      end else begin
        want = pixel_expect.pop_front();
        if (out_data.pixel_color !== want.pixel_color
            || out_data.used_width !== want.used_width) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected color %h width %0d, got color %h width %0d",
                     want.pixel_color, want.used_width,
                     out_data.pixel_color, out_data.used_width);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_no;
    int rmax, cmax;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: empty glyph, half-width cell, all background
    push_read(6'd0, 6'd0);
    push_read(6'd63, 6'd63);
    push_read(6'd15, 6'd7);
    wait_drained();

    // Small glyph, one coverage of each kind, pixels around the edges
    set_cell(32'h1234_5678, 32'h9ABC_DEF0, 7'd4, 7'd4, 8'd2, 7'd8, 7'd8);
    push_load(6'd0, 6'd0, NO_COVER);
    push_load(6'd0, 6'd1, FULL_COVER);
    push_load(6'd0, 6'd2, 8'd1);
    push_load(6'd0, 6'd3, 8'd254);
    push_load(6'd63, 6'd63, 8'hAA);
    push_read(6'd2, 6'd0);
    push_read(6'd2, 6'd1);
    push_read(6'd2, 6'd2);
    push_read(6'd2, 6'd3);
    push_read(6'd0, 6'd0);
    push_read(6'd2, 6'd4);
    push_read(6'd8, 6'd0);
    wait_drained();

    // Zero cell width with a negative offset
    set_cell(32'h0000_0000, 32'hFFFF_FFFF, 7'd2, 7'd2, 8'hFB, 7'd0, 7'd1);
    push_read(6'd0, 6'd0);
    wait_drained();

    // Glyph wider than the cell: cropped on both sides
    set_cell(32'hFF00_FF00, 32'h00FF_00FF, 7'd10, 7'd3, 8'd0, 7'd6, 7'd64);
    push_read(6'd0, 6'd0);
    push_read(6'd1, 6'd5);
    push_read(6'd2, 6'd3);
    wait_drained();

    phase_no = 0;
    while (words_queued < RANDOM_WORDS + 25) begin
      set_cell(rand_color(), rand_color(), rand_glyph_dim(), rand_glyph_dim(),
               rand_offset(), rand_cell_dim(), rand_cell_dim());
      tx_gaps_on = ($urandom_range(0, 2) != 0);
      rx_gaps_on = ($urandom_range(0, 2) != 0);
      if (phase_no == 3) begin
        tx_gaps_on = 1'b0;
        pressure_go = 1'b1;
      end
      // fresh glyph content
      if (glyph_cols() > 0 && glyph_rows() > 0)
        repeat ($urandom_range(4, 16))
          push_load(6'($urandom_range(0, glyph_rows() - 1)),
                    6'($urandom_range(0, glyph_cols() - 1)), rand_cov());
      rmax = (cell_rows() + 1 > 63) ? 63 : cell_rows() + 1;
      cmax = (cell_cols() + 1 > 63) ? 63 : cell_cols() + 1;
      repeat ($urandom_range(20, 50)) begin
        case ($urandom_range(0, 9))
          0: push_load(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), rand_cov());
          1: push_read(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
          default: push_read(6'($urandom_range(0, rmax)), 6'($urandom_range(0, cmax)));
        endcase
      end
      wait_drained();
      phase_no++;
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pixel_expect.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
